FILE: rtl/quantile_threshold_selector_assert.svh
// Assertion macros for the quantile threshold selector
`ifndef QUANTILE_THRESHOLD_SELECTOR_ASSERT_SVH
`define QUANTILE_THRESHOLD_SELECTOR_ASSERT_SVH

// same-cycle implication
`define QTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/qts_pkg.sv
package qts_pkg;

  localparam int unsigned MAX_VALUES  = 1024;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_VALUES);
  localparam int unsigned CNT_W       = $clog2(MAX_VALUES + 1);
  localparam int unsigned FPR_W       = 16;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned PROD_W      = FPR_W + 1 + IDX_W;

  localparam logic [FPR_W-1:0]  FPR_RESET = FPR_W'(655);
  localparam logic [FPR_W:0]    FPR_ONE   = (FPR_W + 1)'(1) << FPR_W;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_VALUES = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED   = 2'd2;

  localparam logic [1:0] RD_IDX   = 2'd0;
  localparam logic [1:0] RD_LOWER = 2'd1;
  localparam logic [1:0] RD_UPPER = 2'd2;

  typedef struct packed {
    logic       load;
    logic       set_idx_top;
    logic       dec_idx;
    logic       wr_shift;
    logic       wr_val_at;
    logic       wr_val_zero;
    logic       inc_count;
    logic       set_drop;
    logic       mul;
    logic [1:0] rd_sel;
    logic       cap_a;
    logic       cap_b;
    logic       emit;
  } qts_cmd_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic full;
    logic empty;
    logic idx_zero;
    logic greater;
    logic out_busy;
  } qts_sts_t;

endpackage

FILE: rtl/qts_ram.sv
module qts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/qts_datapath.sv
module qts_datapath
  import qts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  qts_cmd_t               cmd,
  output qts_sts_t               sts,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_valid,
  input  logic                   in_last,
  input  logic                   cfg_wr_en,
  input  logic [FPR_W-1:0]       cfg_wr_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [VALUE_WIDTH-1:0] out_threshold,
  output logic [STAT_W-1:0]      out_status,
  output logic [CNT_W-1:0]       out_used
);

  localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   drop_r, drop_nxt;
  logic [FPR_W-1:0]       fpr_r, fpr_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [VALUE_WIDTH-1:0] val_r;
  logic                   valid_r;
  logic                   last_r;
  logic [IDX_W-1:0]       idx_r;
  logic [PROD_W-1:0]      prod_r;
  logic [IDX_W-1:0]       lower_r;
  logic [VALUE_WIDTH-1:0] a_r;
  logic [VALUE_WIDTH-1:0] b_r;
  logic [VALUE_WIDTH-1:0] thr_r;
  logic [STAT_W-1:0]      stat_r;
  logic [CNT_W-1:0]       used_r;

  logic [CNT_W-1:0]       nm1;
  logic [CNT_W-1:0]       hi_c;
  logic [CNT_W-1:0]       lower_w;
  logic [IDX_W-1:0]       upper_c;
  logic [VALUE_WIDTH-1:0] avg_c;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  assign nm1     = count_r - CNT_W'(1);
  assign hi_c    = CNT_W'(prod_r >> FPR_W);
  assign lower_w = (hi_c > nm1) ? nm1 : hi_c;
  assign upper_c = ((CNT_W'(lower_r) + CNT_W'(1)) > nm1) ? nm1[IDX_W-1:0]
                                                          : lower_r + IDX_W'(1);
  assign avg_c   = (a_r >> 1) + (b_r >> 1) + VALUE_WIDTH'(a_r[0] & b_r[0]);

  always_comb begin
    ram_we    = cmd.wr_shift | cmd.wr_val_at | cmd.wr_val_zero;
    ram_waddr = cmd.wr_val_zero ? '0 : idx_r + IDX_W'(1);
    ram_wdata = cmd.wr_shift ? ram_rdata : val_r;
    case (cmd.rd_sel)
      RD_LOWER: ram_raddr = lower_w[IDX_W-1:0];
      RD_UPPER: ram_raddr = upper_c;
      default:  ram_raddr = idx_r;
    endcase
  end

  qts_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_VALUES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    count_nxt      = count_r;
    drop_nxt       = drop_r;
    fpr_nxt        = cfg_wr_en ? cfg_wr_data : fpr_r;
    out_tvalid_nxt = out_tready ? 1'b0 : out_tvalid_r;
    if (cmd.inc_count) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.set_drop) begin
      drop_nxt = 1'b1;
    end
    if (cmd.emit) begin
      count_nxt      = '0;
      drop_nxt       = 1'b0;
      out_tvalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      drop_r       <= 1'b0;
      fpr_r        <= FPR_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      drop_r       <= drop_nxt;
      fpr_r        <= fpr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r   <= in_value ^ SIGN_BIT;
      valid_r <= in_valid;
      last_r  <= in_last;
    end
    if (cmd.set_idx_top) begin
      idx_r <= nm1[IDX_W-1:0];
    end else if (cmd.dec_idx) begin
      idx_r <= idx_r - IDX_W'(1);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(FPR_ONE - (FPR_W + 1)'(fpr_r)) * PROD_W'(nm1[IDX_W-1:0]);
    end
    if (cmd.rd_sel == RD_LOWER) begin
      lower_r <= lower_w[IDX_W-1:0];
    end
    if (cmd.cap_a) begin
      a_r <= ram_rdata;
    end
    if (cmd.cap_b) begin
      b_r <= ram_rdata;
    end
    if (cmd.emit) begin
      used_r <= count_r;
      if (count_r == '0) begin
        thr_r  <= '0;
        stat_r <= STAT_NO_VALUES;
      end else begin
        thr_r  <= avg_c ^ SIGN_BIT;
        stat_r <= drop_r ? STAT_DROPPED : STAT_OK;
      end
    end
  end

  assign sts.valid    = valid_r;
  assign sts.last     = last_r;
  assign sts.full     = (count_r == CNT_W'(MAX_VALUES));
  assign sts.empty    = (count_r == '0);
  assign sts.idx_zero = (idx_r == '0);
  assign sts.greater  = (ram_rdata > val_r);
  assign sts.out_busy = out_tvalid_r & ~out_tready;

  assign out_tvalid    = out_tvalid_r;
  assign out_threshold = thr_r;
  assign out_status    = stat_r;
  assign out_used      = used_r;

endmodule

FILE: rtl/qts_ctrl.sv
module qts_ctrl
  import qts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  output logic     in_ready,
  input  qts_sts_t sts,
  output qts_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOADED = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_CMP    = 4'd3;
  localparam logic [3:0] S_WRV    = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_RDA    = 4'd7;
  localparam logic [3:0] S_RDB    = 4'd8;
  localparam logic [3:0] S_CAPA   = 4'd9;
  localparam logic [3:0] S_RES    = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_IDX;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOADED;
        end
      end
      S_LOADED: begin
        if (!sts.valid) begin
          state_nxt = S_CHK;
        end else if (sts.full) begin
          cmd.set_drop = 1'b1;
          state_nxt    = S_CHK;
        end else if (sts.empty) begin
          state_nxt = S_WRV;
        end else begin
          cmd.set_idx_top = 1'b1;
          state_nxt       = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.greater) begin
          cmd.wr_shift = 1'b1;
          if (sts.idx_zero) begin
            state_nxt = S_WRV;
          end else begin
            cmd.dec_idx = 1'b1;
            state_nxt   = S_RD;
          end
        end else begin
          cmd.wr_val_at = 1'b1;
          cmd.inc_count = 1'b1;
          state_nxt     = S_CHK;
        end
      end
      S_WRV: begin
        cmd.wr_val_zero = 1'b1;
        cmd.inc_count   = 1'b1;
        state_nxt       = S_CHK;
      end
      S_CHK: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (sts.empty) begin
          state_nxt = S_RES;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RDA;
      end
      S_RDA: begin
        cmd.rd_sel = RD_LOWER;
        state_nxt  = S_RDB;
      end
      S_RDB: begin
        cmd.rd_sel = RD_UPPER;
        cmd.cap_a  = 1'b1;
        state_nxt  = S_CAPA;
      end
      S_CAPA: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/quantile_threshold_selector.sv
// Quantile threshold selector. Valid metric values are kept in ascending order in a
// 1024-entry RAM by a compare-and-move insertion that walks down from the top entry,
// moving each entry greater than the new value up one place. Invalid items are
// skipped and items that find the store full are dropped. An item with tlast then
// multiplies, reads two RAM entries and averages them (not for an empty run), and
// waits for the result register to empty. The insertion loop on the single read and
// write port of the store sets the rate. No clearing pass after reset; the store is
// emptied after each result.
module quantile_threshold_selector
  import qts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,   // [31:0] metric_value
  input  logic                   in_tuser,   // value_valid
  input  logic                   in_tlast,   // last_item
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [47:0]            out_tdata,  // [31:0] threshold, [42:32] values_used, pad
  output logic [STAT_W-1:0]      out_tuser,  // status
  input  logic                   cfg_wr_en,
  input  logic [FPR_W-1:0]       cfg_wr_data
);

  `include "quantile_threshold_selector_assert.svh"

  qts_cmd_t               cmd;
  qts_sts_t               sts;
  logic                   in_fire;
  logic [VALUE_WIDTH-1:0] thr;
  logic [CNT_W-1:0]       used;
  logic                   res_empty;

  assign in_fire = in_tvalid & in_tready;

  qts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qts_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_tdata[VALUE_WIDTH-1:0]),
    .in_valid      (in_tuser),
    .in_last       (in_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_threshold (thr),
    .out_status    (out_tuser),
    .out_used      (used)
  );

  assign out_tdata = {5'b0, used, thr};
  assign res_empty = out_tvalid && (out_tuser == STAT_NO_VALUES);

  `QTS_ASSERT_NEXT(a_busy_after_transfer, in_fire, !in_tready, "input taken while busy")
  `QTS_ASSERT_NOW(a_empty_result, res_empty, out_tdata == 48'd0, "empty run result not zero")
  `QTS_ASSERT_NOW(a_used_bound, out_tvalid, used <= CNT_W'(MAX_VALUES), "used above capacity")
  `QTS_ASSERT_NOW(a_emit_when_free, cmd.emit, !sts.out_busy, "result overwritten before transfer")

endmodule

FILE: tb/quantile_threshold_selector_test.sv
`timescale 1ns / 100ps

module quantile_threshold_selector_test;
  import qts_pkg::*;

  typedef struct {
    logic signed [31:0] threshold;
    logic [STAT_W-1:0]  status;
    logic [10:0]        used;
  } threshold_rec_t;

  typedef enum int {RX_STREAM, RX_COIN, RX_RARE_STALL, RX_SLOW} rx_mode_t;

  class threshold_scoreboard;
    logic signed [31:0] sorted_metrics[$];
    bit                 dropped;
    logic [FPR_W-1:0]   fraction;
    threshold_rec_t     pending_thresholds[$];
    int                 mismatches;

    function new();
      fraction = FPR_RESET;
      dropped = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task note_metric(logic signed [31:0] metric, bit keep, bit fin);
      int unsigned pos;
      int unsigned n;
      longint unsigned nm1;
      longint unsigned lower;
      longint unsigned upper;
      longint avg;
      threshold_rec_t rec;
      if (keep) begin
        if (sorted_metrics.size() >= MAX_VALUES) begin
          dropped = 1;
        end else begin
          pos = sorted_metrics.size();
          while (pos > 0 && sorted_metrics[pos-1] > metric) pos--;
          sorted_metrics.insert(pos, metric);
        end
      end
      if (!fin) return;
      n = sorted_metrics.size();
      if (n == 0) begin
        rec.threshold = '0;
        rec.status = STAT_NO_VALUES;
        rec.used = '0;
      end else begin
        nm1 = n - 1;
        lower = ((longint'(65536) - longint'(fraction)) * nm1) >> 16;
        if (lower > nm1) lower = nm1;
        upper = (lower + 1 > nm1) ? nm1 : lower + 1;
        avg = (longint'(sorted_metrics[lower]) + longint'(sorted_metrics[upper])) >>> 1;
        rec.threshold = avg[31:0];
        rec.status = dropped ? STAT_DROPPED : STAT_OK;
        rec.used = n[10:0];
      end
      pending_thresholds.insert(pending_thresholds.size(), rec);
      sorted_metrics.delete();
      dropped = 0;
    endtask

    task check_threshold(logic signed [31:0] thr, logic [STAT_W-1:0] status,
                         logic [10:0] used);
      threshold_rec_t want;
      if (pending_thresholds.size() == 0) begin
        report($sformatf("result with none pending: thr=%0d status=%0d used=%0d",
                         thr, status, used));
        return;
      end
      want = pending_thresholds.pop_front();
      if (thr !== want.threshold)
        report($sformatf("threshold %0d, expected %0d", thr, want.threshold));
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
      if (used !== want.used)
        report($sformatf("values_used %0d, expected %0d", used, want.used));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;   // [31:0] metric_value
  logic              in_tuser = 1'b0; // value_valid
  logic              in_tlast = 1'b0; // last_item
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;       // [31:0] threshold, [42:32] values_used, pad
  logic [STAT_W-1:0] out_tuser;       // status
  logic              cfg_wr_en = 1'b0;
  logic [FPR_W-1:0]  cfg_wr_data = '0;

  threshold_scoreboard sb = new();

  int       burst_left = 0;
  rx_mode_t rx_mode = RX_STREAM;
  int       rx_hold = 0;

  quantile_threshold_selector uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_threshold(out_tdata[31:0], out_tuser, out_tdata[42:32]);
    if (rx_hold == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_hold = $urandom_range(20, 200);
    end else begin
      rx_hold--;
    end
    case (rx_mode)
      RX_STREAM:     out_tready <= 1'b1;
      RX_COIN:       out_tready <= $urandom_range(0, 1);
      RX_RARE_STALL: out_tready <= ($urandom_range(0, 7) != 0);
      default:       out_tready <= ((rx_hold % 32) < 3);
    endcase
  end

  task automatic send_metric(logic signed [31:0] metric, bit keep, bit fin);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= metric;
    in_tuser  <= keep;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_metric(metric, keep, fin);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_thresholds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_fraction(logic [FPR_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.fraction = value;
  endtask

  function automatic logic signed [31:0] pick_metric();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3:    return $signed(32'($urandom_range(0, 15))) - 8;
      4:       return $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic random_run(output int sent);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 12);
    for (int i = 0; i < len; i++)
      send_metric(pick_metric(), $urandom_range(0, 99) < 85, 1'b0);
    send_metric(pick_metric(), $urandom_range(0, 1), 1'b1);
    sent = len + 1;
  endtask

  // mostly ascending so the insertion stays cheap; a few random values go deep
  task automatic fill_run(bit overflow);
    int     kept;
    int     target;
    longint level;
    kept = 0;
    target = MAX_VALUES + (overflow ? $urandom_range(1, 6) : 0);
    level = -64'sd2147483648 + longint'($urandom_range(0, 1 << 20));
    while (kept < target) begin
      if ($urandom_range(0, 19) == 0) begin
        send_metric(pick_metric(), 1'b0, 1'b0);
      end else if ($urandom_range(0, 63) == 0) begin
        send_metric(pick_metric(), 1'b1, 1'b0);
        kept++;
      end else begin
        if ($urandom_range(0, 3) != 0) level += $urandom_range(1, 1 << 21);
        if (level > 64'sd2147483647) level = 64'sd2147483647;
        send_metric(level[31:0], 1'b1, 1'b0);
        kept++;
      end
    end
    if (overflow) send_metric(pick_metric(), 1'b1, 1'b1);
    else send_metric(pick_metric(), 1'b0, 1'b1);
  endtask

  initial begin
    int phase_items;
    int sent;
    logic [FPR_W-1:0] frac;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset fraction: empty run, single value, extremes, duplicates
    send_metric(32'sh0000_0000, 1'b0, 1'b1);
    send_metric(32'sh7FFF_FFFF, 1'b1, 1'b1);
    send_metric(32'sh8000_0000, 1'b1, 1'b0);
    send_metric(32'sh7FFF_FFFF, 1'b1, 1'b1);
    send_metric(32'sd5, 1'b1, 1'b0);
    send_metric(32'sd5, 1'b1, 1'b0);
    send_metric(-32'sd3, 1'b0, 1'b0);
    send_metric(32'sd5, 1'b1, 1'b0);
    send_metric(32'sd6, 1'b0, 1'b1);

    write_fraction(16'hFFFF);
    send_metric(32'sd10, 1'b1, 1'b0);
    send_metric(-32'sd20, 1'b1, 1'b0);
    send_metric(32'sd30, 1'b1, 1'b0);
    send_metric(-32'sd41, 1'b1, 1'b0);
    send_metric(32'sd0, 1'b1, 1'b1);

    write_fraction(16'd1);
    send_metric(32'sd1, 1'b1, 1'b0);
    send_metric(32'sd2, 1'b1, 1'b0);
    send_metric(32'sd3, 1'b1, 1'b1);

    write_fraction(16'd0);
    send_metric(-32'sd7, 1'b1, 1'b0);
    send_metric(-32'sd8, 1'b1, 1'b0);
    send_metric(-32'sd9, 1'b1, 1'b1);
    send_metric(32'sd4, 1'b0, 1'b0);
    send_metric(32'sd4, 1'b0, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       frac = 16'd1;
        1:       frac = 16'hFFFF;
        2:       frac = 16'd0;
        3:       frac = FPR_RESET;
        4:       frac = 16'h8000;
        default: frac = FPR_W'($urandom_range(1, 65535));
      endcase
      write_fraction(frac);
      if (ph == 4) fill_run(1'b1);
      phase_items = 0;
      while (phase_items < 115) begin
        random_run(sent);
        phase_items += sent;
      end
    end

    settle();
    repeat (30) @(posedge clk);
    if (sb.pending_thresholds.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_thresholds.size()));
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
